>>> rtl/chist_pkg.sv
// ----------------------------------------------------------------------------
// chist_pkg: shared constants and types of the chromaticity histogram
// Holds the map geometry, the Q16 color matrix, request and status codes
// and the control word that drives the bin memories.
// ----------------------------------------------------------------------------
`default_nettype none

package chist_pkg;

   localparam int X_BINS     = 49;
   localparam int Y_BINS     = 54;
   localparam int MAP_SIZE   = X_BINS * Y_BINS;
   localparam int ADDR_W     = $clog2(MAP_SIZE);
   localparam int COUNT_BITS = 16;
   localparam int OFS_W      = 6;
   localparam int IDX_W      = 6;
   localparam int Q_W        = 7;   // quotient of 100*c/sum is at most 100
   localparam int CX_W       = 24;
   localparam int CY_W       = 24;
   localparam int CZ_W       = 25;
   localparam int SUM_W      = 26;
   localparam int NUM_W      = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // sRGB to XYZ in unsigned Q16.
   localparam logic [15:0] C_XR = 16'd27031;
   localparam logic [15:0] C_XG = 16'd23434;
   localparam logic [15:0] C_XB = 16'd11824;
   localparam logic [15:0] C_YR = 16'd13938;
   localparam logic [15:0] C_YG = 16'd46869;
   localparam logic [15:0] C_YB = 16'd4730;
   localparam logic [15:0] C_ZR = 16'd1267;
   localparam logic [15:0] C_ZG = 16'd7811;
   localparam logic [15:0] C_ZB = 16'd62274;
   localparam logic [6:0]  C_PCT = 7'd100;

   // Request kinds.
   localparam logic [1:0] REQ_PIXEL = 2'd0;
   localparam logic [1:0] REQ_FOLD  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   // Result status codes.
   localparam logic [1:0] STAT_MARKED = 2'd0;
   localparam logic [1:0] STAT_ZERO   = 2'd1;
   localparam logic [1:0] STAT_RANGE  = 2'd2;
   localparam logic [1:0] STAT_DONE   = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_X_OFFSET = 1'b0;
   localparam logic CSR_Y_OFFSET = 1'b1;

   typedef struct packed {
      logic                  pres_we;
      logic                  pres_wd;
      logic                  tot_we;
      logic [COUNT_BITS-1:0] tot_wd;
      logic [ADDR_W-1:0]     waddr;
      logic [ADDR_W-1:0]     raddr;
   } mem_req_type;

   function automatic logic [ADDR_W-1:0] bin_addr(input logic [IDX_W-1:0] bx,
                                                  input logic [IDX_W-1:0] by);
      logic [ADDR_W-1:0] row;
      row = ADDR_W'(bx) * ADDR_W'(Y_BINS);
      return row + ADDR_W'(by);
   endfunction

endpackage

`default_nettype wire

>>> rtl/chist_div.sv
// ----------------------------------------------------------------------------
// chist_div: iterative chromaticity divider
// Computes floor(100*cx/sum) and floor(100*cy/sum) side by side, one
// quotient bit per cycle, and raises done after the last bit.
// ----------------------------------------------------------------------------
`default_nettype none

module chist_div (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   input  wire  [chist_pkg::CX_W-1:0]           cx,
   input  wire  [chist_pkg::CY_W-1:0]           cy,
   input  wire  [chist_pkg::SUM_W-1:0]          sum,
   output logic                                 done,
   output logic [chist_pkg::Q_W-1:0]            qx,
   output logic [chist_pkg::Q_W-1:0]            qy
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [2:0]                    step_ff, step_in;
   logic [chist_pkg::NUM_W-1:0]   remx_ff, remx_in;
   logic [chist_pkg::NUM_W-1:0]   remy_ff, remy_in;
   logic [chist_pkg::SUM_W-1:0]   den_ff, den_in;
   logic [chist_pkg::Q_W-1:0]     qx_ff, qx_in;
   logic [chist_pkg::Q_W-1:0]     qy_ff, qy_in;
   logic [chist_pkg::NUM_W-1:0]   trial;
   logic                          bit_x, bit_y;

   assign trial = chist_pkg::NUM_W'(den_ff) << step_ff;
   assign bit_x = remx_ff >= trial;
   assign bit_y = remy_ff >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      remx_in = remx_ff;
      remy_in = remy_ff;
      den_in  = den_ff;
      qx_in   = qx_ff;
      qy_in   = qy_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'(chist_pkg::Q_W - 1);
         remx_in = chist_pkg::NUM_W'(cx) * chist_pkg::NUM_W'(chist_pkg::C_PCT);
         remy_in = chist_pkg::NUM_W'(cy) * chist_pkg::NUM_W'(chist_pkg::C_PCT);
         den_in  = sum;
         qx_in   = '0;
         qy_in   = '0;
      end else if (busy_ff) begin
         if (bit_x) remx_in = remx_ff - trial;
         if (bit_y) remy_in = remy_ff - trial;
         qx_in = {qx_ff[chist_pkg::Q_W-2:0], bit_x};
         qy_in = {qy_ff[chist_pkg::Q_W-2:0], bit_y};
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      remx_ff <= remx_in;
      remy_ff <= remy_in;
      den_ff  <= den_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
   end

   assign done = done_ff;
   assign qx   = qx_ff;
   assign qy   = qy_ff;

endmodule

`default_nettype wire

>>> rtl/chist_mem.sv
// ----------------------------------------------------------------------------
// chist_mem: presence map and bin total memories
// Two single-port-write, single-port-read arrays sharing one write and one
// read address, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chist_mem (
   input  wire                                   clock,
   input  wire  chist_pkg::mem_req_type          req,
   output logic                                  pres_rdata,
   output logic [chist_pkg::COUNT_BITS-1:0]      tot_rdata
);

   logic                              pres_mem [chist_pkg::MAP_SIZE];
   logic [chist_pkg::COUNT_BITS-1:0]  tot_mem  [chist_pkg::MAP_SIZE];

   always_ff @(posedge clock) begin
      if (req.pres_we) pres_mem[req.waddr] <= req.pres_wd;
      pres_rdata <= pres_mem[req.raddr];
   end

   always_ff @(posedge clock) begin
      if (req.tot_we) tot_mem[req.waddr] <= req.tot_wd;
      tot_rdata <= tot_mem[req.raddr];
   end

endmodule

`default_nettype wire

>>> rtl/chromaticity_histogram.sv
// ----------------------------------------------------------------------------
// chromaticity_histogram: CIE xy chromaticity presence histogram
// Converts RGB pixels to XYZ, bins the xy chromaticity, marks the bin in a
// per-image presence map and folds the map into saturating bin totals.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    tuser: req_type; tdata: pixel and read bin
// rsp      out  rsp_tvalid/tready    tuser: status; tdata: bins and counts
// csr      in   csr_we               csr_index selects x_offset or y_offset
//
// A pixel passes in order through the color matrix, the channel sum, a
// zero check, the divide state (the quotient bits, then the done cycle),
// the map mark and the load of the output register; an all-black pixel
// goes from the check straight to the output register. A bin read is
// issued at acceptance and its data taken in the read state. Fold and
// clear commands sweep all 2646 entries, one per memory port cycle.
// After reset a clearing pass over all entries runs before the first word
// is accepted. The result sits in an output register, so a stalled
// response channel holds only the next result, not the next acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module chromaticity_histogram (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [1:0]  req_tuser,   // req_type
   input  wire  [39:0] req_tdata,   // red, green, blue, read_x, read_y, zero pad
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [1:0]  rsp_tuser,   // status
   output logic [47:0] rsp_tdata,   // bin_x, bin_y, bin_count, max_count, zero pad
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [5:0]  csr_wdata
);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_SUM   = 4'd2;
   localparam logic [3:0] ST_CHK   = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_MARK  = 4'd5;
   localparam logic [3:0] ST_READ  = 4'd6;
   localparam logic [3:0] ST_FOLD  = 4'd7;
   localparam logic [3:0] ST_CLEAR = 4'd8;
   localparam logic [3:0] ST_RESP  = 4'd9;

   localparam int AW = chist_pkg::ADDR_W;
   localparam int CW = chist_pkg::COUNT_BITS;
   localparam logic [AW-1:0] LAST_ADDR = AW'(chist_pkg::MAP_SIZE - 1);

   logic [3:0]                   state_ff, state_in;
   logic [5:0]                   xoff_ff, xoff_in;
   logic [5:0]                   yoff_ff, yoff_in;
   logic [7:0]                   r_ff, r_in, g_ff, g_in, b_ff, b_in;
   logic [5:0]                   rx_ff, rx_in, ry_ff, ry_in;
   logic [chist_pkg::CX_W-1:0]   cx_ff, cx_in;
   logic [chist_pkg::CY_W-1:0]   cy_ff, cy_in;
   logic [chist_pkg::CZ_W-1:0]   cz_ff, cz_in;
   logic [chist_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [AW-1:0]                rd_addr_ff, rd_addr_in;
   logic [AW-1:0]                wa_ff, wa_in;
   logic                         iss_ff, iss_in;
   logic                         v1_ff, v1_in;
   logic                         clr_resp_ff, clr_resp_in;
   logic [CW-1:0]                peak_ff, peak_in;
   logic [5:0]                   res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [1:0]                   res_st_ff, res_st_in;
   logic [CW-1:0]                res_cnt_ff, res_cnt_in;
   logic                         out_v_ff, out_v_in;
   logic [5:0]                   out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [1:0]                   out_st_ff, out_st_in;
   logic [CW-1:0]                out_cnt_ff, out_cnt_in;
   logic [CW-1:0]                out_max_ff, out_max_in;

   chist_pkg::mem_req_type       mem;
   logic                         pres_rdata;
   logic [CW-1:0]                tot_rdata;
   logic                         div_start, div_done;
   logic [chist_pkg::Q_W-1:0]    qx, qy;
   logic [7:0]                   dx, dy;
   logic                         out_free, req_fire;
   logic [CW-1:0]                tot_next;
   logic [1:0]                   req_kind;

   assign req_kind   = req_tuser;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_v_ff || rsp_tready;
   assign div_start  = (state_ff == ST_CHK) && (sum_ff != '0);

   // Chromaticity index minus the configured offsets, with a borrow bit.
   assign dx = {1'b0, qx} - {2'b00, xoff_ff};
   assign dy = {1'b0, qy} - {2'b00, yoff_ff};

   // Saturating add of the presence bit into the total being swept.
   assign tot_next = (pres_rdata && tot_rdata != chist_pkg::COUNT_MAX)
                     ? tot_rdata + CW'(1) : tot_rdata;

   chist_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .cx    (cx_ff),
      .cy    (cy_ff),
      .sum   (sum_ff),
      .done  (div_done),
      .qx    (qx),
      .qy    (qy)
   );

   chist_mem u_mem (
      .clock      (clock),
      .req        (mem),
      .pres_rdata (pres_rdata),
      .tot_rdata  (tot_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      xoff_in     = xoff_ff;
      yoff_in     = yoff_ff;
      r_in        = r_ff;
      g_in        = g_ff;
      b_in        = b_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      cz_in       = cz_ff;
      sum_in      = sum_ff;
      rd_addr_in  = rd_addr_ff;
      wa_in       = wa_ff;
      iss_in      = iss_ff;
      v1_in       = 1'b0;
      clr_resp_in = clr_resp_ff;
      peak_in     = peak_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;
      res_st_in   = res_st_ff;
      res_cnt_in  = res_cnt_ff;
      out_v_in    = out_v_ff && !rsp_tready;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_st_in   = out_st_ff;
      out_cnt_in  = out_cnt_ff;
      out_max_in  = out_max_ff;

      mem         = '0;
      mem.raddr   = rd_addr_ff;

      if (csr_we) begin
         unique case (csr_index)
            chist_pkg::CSR_X_OFFSET: xoff_in = csr_wdata;
            chist_pkg::CSR_Y_OFFSET: yoff_in = csr_wdata;
            default:                 xoff_in = xoff_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               r_in       = req_tdata[7:0];
               g_in       = req_tdata[15:8];
               b_in       = req_tdata[23:16];
               rx_in      = req_tdata[29:24];
               ry_in      = req_tdata[35:30];
               res_x_in   = '0;
               res_y_in   = '0;
               res_cnt_in = '0;
               res_st_in  = chist_pkg::STAT_DONE;
               unique case (req_kind)
                  chist_pkg::REQ_PIXEL: state_in = ST_MUL;
                  chist_pkg::REQ_FOLD: begin
                     rd_addr_in = '0;
                     iss_in     = 1'b1;
                     state_in   = ST_FOLD;
                  end
                  chist_pkg::REQ_READ: begin
                     // The read is issued at acceptance so its data is there
                     // in the following cycle.
                     mem.raddr = chist_pkg::bin_addr(req_tdata[29:24], req_tdata[35:30]);
                     state_in  = ST_READ;
                  end
                  chist_pkg::REQ_CLEAR: begin
                     rd_addr_in  = '0;
                     clr_resp_in = 1'b1;
                     peak_in     = '0;
                     state_in    = ST_CLEAR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_MUL: begin
            cx_in = chist_pkg::CX_W'(chist_pkg::C_XR * r_ff)
                  + chist_pkg::CX_W'(chist_pkg::C_XG * g_ff)
                  + chist_pkg::CX_W'(chist_pkg::C_XB * b_ff);
            cy_in = chist_pkg::CY_W'(chist_pkg::C_YR * r_ff)
                  + chist_pkg::CY_W'(chist_pkg::C_YG * g_ff)
                  + chist_pkg::CY_W'(chist_pkg::C_YB * b_ff);
            cz_in = chist_pkg::CZ_W'(chist_pkg::C_ZR * r_ff)
                  + chist_pkg::CZ_W'(chist_pkg::C_ZG * g_ff)
                  + chist_pkg::CZ_W'(chist_pkg::C_ZB * b_ff);
            state_in = ST_SUM;
         end

         ST_SUM: begin
            sum_in = chist_pkg::SUM_W'(cx_ff) + chist_pkg::SUM_W'(cy_ff)
                   + chist_pkg::SUM_W'(cz_ff);
            state_in = ST_CHK;
         end

         ST_CHK: begin
            // An all-black pixel has no chromaticity and marks nothing.
            if (sum_ff == '0) begin
               res_st_in = chist_pkg::STAT_ZERO;
               state_in  = ST_RESP;
            end else begin
               state_in  = ST_DIV;
            end
         end

         ST_DIV: begin
            if (div_done) state_in = ST_MARK;
         end

         ST_MARK: begin
            if (dx[7] || dy[7] || dx >= 8'(chist_pkg::X_BINS)
                || dy >= 8'(chist_pkg::Y_BINS)) begin
               res_st_in = chist_pkg::STAT_RANGE;
            end else begin
               mem.pres_we = 1'b1;
               mem.pres_wd = 1'b1;
               mem.waddr   = chist_pkg::bin_addr(dx[5:0], dy[5:0]);
               res_x_in    = dx[5:0];
               res_y_in    = dy[5:0];
               res_st_in   = chist_pkg::STAT_MARKED;
            end
            state_in = ST_RESP;
         end

         ST_READ: begin
            // Read data for the address issued at acceptance arrives this cycle.
            res_x_in = rx_ff;
            res_y_in = ry_ff;
            if (rx_ff >= 6'(chist_pkg::X_BINS) || ry_ff >= 6'(chist_pkg::Y_BINS)) begin
               res_st_in = chist_pkg::STAT_RANGE;
            end else begin
               res_cnt_in = tot_rdata;
            end
            state_in = ST_RESP;
         end

         ST_FOLD: begin
            // Read at rd_addr_ff, write back in the next cycle at wa_ff.
            v1_in = iss_ff;
            wa_in = rd_addr_ff;
            if (iss_ff) begin
               if (rd_addr_ff == LAST_ADDR) iss_in = 1'b0;
               else rd_addr_in = rd_addr_ff + AW'(1);
            end
            if (v1_ff) begin
               mem.pres_we = 1'b1;
               mem.pres_wd = 1'b0;
               mem.tot_we  = 1'b1;
               mem.tot_wd  = tot_next;
               mem.waddr   = wa_ff;
               if (tot_next > peak_ff) peak_in = tot_next;
            end
            if (!iss_ff && !v1_ff) state_in = ST_RESP;
         end

         ST_CLEAR: begin
            mem.pres_we = 1'b1;
            mem.pres_wd = 1'b0;
            mem.tot_we  = 1'b1;
            mem.tot_wd  = '0;
            mem.waddr   = rd_addr_ff;
            if (rd_addr_ff == LAST_ADDR) begin
               state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end else begin
               rd_addr_in = rd_addr_ff + AW'(1);
            end
         end

         ST_RESP: begin
            if (out_free) begin
               out_v_in   = 1'b1;
               out_x_in   = res_x_ff;
               out_y_in   = res_y_ff;
               out_st_in  = res_st_ff;
               out_cnt_in = res_cnt_ff;
               out_max_in = peak_ff;
               state_in   = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // Reset starts a silent clearing pass over both memories.
         state_ff    <= ST_CLEAR;
         xoff_ff     <= 6'd15;
         yoff_ff     <= 6'd6;
         rd_addr_ff  <= '0;
         iss_ff      <= 1'b0;
         v1_ff       <= 1'b0;
         clr_resp_ff <= 1'b0;
         peak_ff     <= '0;
         out_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         xoff_ff     <= xoff_in;
         yoff_ff     <= yoff_in;
         rd_addr_ff  <= rd_addr_in;
         iss_ff      <= iss_in;
         v1_ff       <= v1_in;
         clr_resp_ff <= clr_resp_in;
         peak_ff     <= peak_in;
         out_v_ff    <= out_v_in;
      end
      r_ff       <= r_in;
      g_ff       <= g_in;
      b_ff       <= b_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      cz_ff      <= cz_in;
      sum_ff     <= sum_in;
      wa_ff      <= wa_in;
      res_x_ff   <= res_x_in;
      res_y_ff   <= res_y_in;
      res_st_ff  <= res_st_in;
      res_cnt_ff <= res_cnt_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_st_ff  <= out_st_in;
      out_cnt_ff <= out_cnt_in;
      out_max_ff <= out_max_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_st_ff;
   assign rsp_tdata  = {4'b0000, out_max_ff, out_cnt_ff, out_y_ff, out_x_ff};

`ifndef SYNTHESIS
   a_sweep_in_map: assert property (@(posedge clock) disable iff (reset)
      rd_addr_ff <= LAST_ADDR)
      else $error("sweep address beyond the map");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem.tot_we && !mem.pres_we)
      else $error("memory written while idle");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) && !reset |-> state_ff == ST_CLEAR)
      else $error("no clearing pass after reset");

   a_fold_writes_behind: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> $past(rd_addr_ff) == wa_ff)
      else $error("fold write address out of step with its read");
`endif

endmodule

`default_nettype wire
